// ===== rtl/tccw_pkg.sv =====
package tccw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int LINES_W = 8;

    localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;

    localparam logic [CHAR_W-1:0] RESET_GLYPH = 8'd95;
    localparam logic [CHAR_W-1:0] RESET_ATTR  = 8'd15;
    localparam logic [CELL_W-1:0] RESET_CELL  = {RESET_ATTR, RESET_GLYPH};

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLYPH,
        CFG_ATTR
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_CLEAR,
        CMD_SCROLL
    } cmd_t;

    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_FILL,
        MOP_PUT,
        MOP_GLYPH,
        MOP_COPY_RD,
        MOP_COPY_WR,
        MOP_ZERO,
        MOP_READ
    } mem_op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_ZERO,
        ST_GLYPH,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [CHAR_W-1:0]  char_code;
        logic [CHAR_W-1:0]  char_attr;
        logic [ROW_W-1:0]   cell_row;
        logic [COL_W-1:0]   cell_col;
        logic [LINES_W-1:0] scroll_lines;
    } in_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } out_item_t;

    typedef struct packed {
        logic    load_item;
        logic    cnt_inc;
        logic    cur_advance;
        logic    load_result;
        mem_op_t mop;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t in_cmd;
        logic in_none;
        logic in_all;
        cmd_t item_cmd;
        logic cnt_last;
        logic cnt_keep_end;
        logic wrap_scroll;
    } dp_status_t;

endpackage

// ===== rtl/tccw_datapath.sv =====
module tccw_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tccw_pkg::in_item_t             cmd_item,
    input  logic                           cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  tccw_pkg::dp_cmd_t              ctl,
    output tccw_pkg::dp_status_t           sts,
    output tccw_pkg::out_item_t            res_item
);
    import tccw_pkg::*;

    in_item_t          item_reg;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] off_reg, keep_last_reg;
    logic              scrolled_reg, scrolled_next;
    logic [CHAR_W-1:0] glyph_reg, attr_reg;
    logic [CELL_W-1:0] rdata_reg;
    out_item_t         res_reg;

    logic [CELL_W-1:0] mem [CELLS];
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we, mem_re;
    logic [CELL_W-1:0] mem_wdata;

    cmd_t              in_cmd, item_cmd;
    logic              in_none, in_all;
    logic [ROW_W-1:0]  in_rows, shift_rows;
    logic [ADDR_W-1:0] shift_off, keep_last;
    logic              is_cr, is_lf, col_end, row_end, adv_wrap;
    logic [CHAR_W-1:0] put_char;
    logic [ADDR_W-1:0] cur_pos, cell_pos, copy_src;
    logic              read_ok;

    assign in_cmd   = cmd_t'(cmd_item.command);
    assign item_cmd = cmd_t'(item_reg.command);
    assign in_none  = (cmd_item.scroll_lines == '0);
    assign in_all   = (cmd_item.scroll_lines >= LINES_W'(ROWS));
    assign in_rows  = cmd_item.scroll_lines[ROW_W-1:0];

    // A write that runs off the bottom shifts the screen by exactly one row.
    assign shift_rows = (in_cmd == CMD_WRITE) ? ROW_W'(1) : in_rows;
    assign shift_off  = ADDR_W'(shift_rows) * ADDR_W'(COLUMNS);
    assign keep_last  = ADDR_W'(CELLS - 1) - shift_off;

    assign is_cr    = (item_reg.char_code == CODE_CR);
    assign is_lf    = (item_reg.char_code == CODE_LF);
    assign put_char = (is_cr || is_lf) ? CODE_SPACE : item_reg.char_code;
    assign col_end  = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign row_end  = (cur_row_reg == ROW_W'(ROWS - 1));
    assign adv_wrap = is_lf || (!is_cr && col_end);

    assign cur_pos  = ADDR_W'(cur_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_reg);
    assign cell_pos = ADDR_W'(item_reg.cell_row) * ADDR_W'(COLUMNS)
                      + ADDR_W'(item_reg.cell_col);
    assign read_ok  = (item_reg.cell_row < ROW_W'(ROWS))
                      && (item_reg.cell_col < COL_W'(COLUMNS));
    assign copy_src = cnt_reg + off_reg;

    always_comb
    begin
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        scrolled_next = scrolled_reg;
        if (ctl.load_item)
        begin
            scrolled_next = (in_cmd == CMD_SCROLL) && !in_none;
            if ((in_cmd == CMD_SCROLL) && !in_none)
            begin
                if (in_all)
                begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                end
                else
                begin
                    cur_row_next = (cur_row_reg > in_rows) ? (cur_row_reg - in_rows) : '0;
                end
            end
        end
        else if (ctl.cur_advance)
        begin
            if (adv_wrap)
            begin
                // On the last row the cursor stays there; the screen scrolls instead.
                cur_col_next = '0;
                cur_row_next = row_end ? cur_row_reg : (cur_row_reg + ROW_W'(1));
                if (row_end)
                begin
                    scrolled_next = 1'b1;
                end
            end
            else if (is_cr)
            begin
                cur_col_next = '0;
            end
            else
            begin
                cur_col_next = cur_col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.load_item)
        begin
            cnt_next = '0;
        end
        else if (ctl.cnt_inc)
        begin
            cnt_next = cnt_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            cnt_reg      <= '0;
            scrolled_reg <= 1'b0;
            glyph_reg    <= RESET_GLYPH;
            attr_reg     <= RESET_ATTR;
        end
        else
        begin
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            cnt_reg      <= cnt_next;
            scrolled_reg <= scrolled_next;
            if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_GLYPH))
            begin
                glyph_reg <= cfg_data[CHAR_W-1:0];
            end
            if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_ATTR))
            begin
                attr_reg <= cfg_data[CHAR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg      <= cmd_item;
            off_reg       <= shift_off;
            keep_last_reg <= keep_last;
        end
    end

    always_comb
    begin
        mem_addr  = cnt_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = '0;
        unique case (ctl.mop)
            MOP_NONE:
            begin
            end
            MOP_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = (cnt_reg == '0) ? RESET_CELL : '0;
            end
            MOP_PUT:
            begin
                mem_addr  = cur_pos;
                mem_we    = 1'b1;
                mem_wdata = {item_reg.char_attr, put_char};
            end
            MOP_GLYPH:
            begin
                mem_addr  = cur_pos;
                mem_we    = 1'b1;
                mem_wdata = {attr_reg, glyph_reg};
            end
            MOP_COPY_RD:
            begin
                mem_addr = copy_src;
                mem_re   = 1'b1;
            end
            MOP_COPY_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
            end
            MOP_ZERO:
            begin
                mem_we = 1'b1;
            end
            MOP_READ:
            begin
                mem_addr = cell_pos;
                mem_re   = read_ok;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_result)
        begin
            res_reg.cell_value <= ((item_cmd == CMD_READ) && read_ok) ? rdata_reg : '0;
            res_reg.cursor_row <= cur_row_reg;
            res_reg.cursor_col <= cur_col_reg;
            res_reg.scrolled   <= scrolled_reg;
        end
    end

    assign res_item = res_reg;

    assign sts.in_cmd       = in_cmd;
    assign sts.in_none      = in_none;
    assign sts.in_all       = in_all;
    assign sts.item_cmd     = item_cmd;
    assign sts.cnt_last     = (cnt_reg == ADDR_W'(CELLS - 1));
    assign sts.cnt_keep_end = (cnt_reg == keep_last_reg);
    assign sts.wrap_scroll  = adv_wrap && row_end;

endmodule

// ===== rtl/tccw_ctrl.sv =====
module tccw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    input  tccw_pkg::dp_status_t sts,
    output tccw_pkg::dp_cmd_t    ctl
);
    import tccw_pkg::*;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   res_free;

    // The result register can take a new result once the old one is gone or leaving.
    assign res_free = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sts.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (sts.in_cmd)
                        CMD_WRITE:  state_next = ST_PUT;
                        CMD_READ:   state_next = ST_READ;
                        CMD_CLEAR:  state_next = ST_ZERO;
                        CMD_SCROLL:
                        begin
                            priority if (sts.in_none)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (sts.in_all)
                            begin
                                state_next = ST_ZERO;
                            end
                            else
                            begin
                                state_next = ST_COPY_RD;
                            end
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                state_next = sts.wrap_scroll ? ST_COPY_RD : ST_GLYPH;
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                state_next = sts.cnt_keep_end ? ST_ZERO : ST_COPY_RD;
            end
            ST_ZERO:
            begin
                if (sts.cnt_last)
                begin
                    state_next = (sts.item_cmd == CMD_CLEAR) ? ST_DONE : ST_GLYPH;
                end
            end
            ST_GLYPH:
            begin
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready       = 1'b0;
        ctl.load_item   = 1'b0;
        ctl.cnt_inc     = 1'b0;
        ctl.cur_advance = 1'b0;
        ctl.load_result = 1'b0;
        ctl.mop         = MOP_NONE;
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.mop     = MOP_FILL;
                ctl.cnt_inc = 1'b1;
            end
            ST_IDLE:
            begin
                cmd_ready     = 1'b1;
                ctl.load_item = cmd_valid;
            end
            ST_PUT:
            begin
                ctl.mop         = MOP_PUT;
                ctl.cur_advance = 1'b1;
            end
            ST_COPY_RD:
            begin
                ctl.mop = MOP_COPY_RD;
            end
            ST_COPY_WR:
            begin
                ctl.mop     = MOP_COPY_WR;
                ctl.cnt_inc = 1'b1;
            end
            ST_ZERO:
            begin
                ctl.mop     = MOP_ZERO;
                ctl.cnt_inc = 1'b1;
            end
            ST_GLYPH:
            begin
                ctl.mop = MOP_GLYPH;
            end
            ST_READ:
            begin
                ctl.mop = MOP_READ;
            end
            ST_DONE:
            begin
                ctl.load_result = res_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctl.load_result)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

// ===== rtl/text_console_char_writer_unit.sv =====
// Text console: an 80 x 25 screen of 16-bit cells (attribute above character) and a cursor.
// Commands arrive as transactions on the cmd channel (valid/ready) and each one produces
// exactly one result transaction on the res channel: the cell read, if any, the cursor
// position afterwards and a scrolled flag. The cfg port sets the cursor glyph and its
// attribute with a single-cycle write; write it only while the block is idle.
// One screen memory port is shared by every step, so work is counted in memory accesses.
// A read passes through the read and done states before its result becomes valid, and a
// character write through the put, glyph and done states; the block is ready for the next
// command in the same cycle as the result becomes valid. A write that runs off the bottom
// row, and a scroll by n rows, copy each kept cell with a read and a write access and clear
// each freed cell with one write access; a clear zeroes every cell.
// After reset the block first sweeps the whole screen memory, leaving the cursor
// glyph at the home cell; cmd_ready stays low during that pass.
// The result sits in an output register, so a command can be accepted while res_ready is
// low; that command then waits at its end until the earlier result has been taken.
module text_console_char_writer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  tccw_pkg::in_item_t              cmd_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output tccw_pkg::out_item_t             res_item,
    input  logic                            cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tccw_pkg::*;

    dp_cmd_t    ctl;
    dp_status_t sts;

    tccw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    tccw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .sts       (sts),
        .res_item  (res_item)
    );

    // The reported cursor always lies on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.cursor_row < ROW_W'(ROWS))
                      && (res_item.cursor_col < COL_W'(COLUMNS)))
        else $error("cursor outside the screen");

    // Every command leaves the idle state when it is accepted, so ready drops right after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command accepted while the previous one is in progress");

    // Only a read returns cell data, and a read never scrolls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_item.cell_value != '0)) |-> !res_item.scrolled)
        else $error("scrolled flag set on a read result");

endmodule
